// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is asserted
`define TVKT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define TVKT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tvkt_pkg.sv =====
// types, constants and codes of the two value key table
package tvkt_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [CAP_W-1:0]             cap_t;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_EMIT
    } state_t;

    typedef struct packed {
        op_t   operation;
        data_t key;
        data_t value;
    } in_t;

    typedef struct packed {
        status_t status;
        data_t   first_value;
        logic    first_found;
        data_t   second_value;
        logic    second_found;
        cnt_t    entry_count;
        logic    is_empty;
        logic    is_full;
    } out_t;

    // port of the pair store: one write and one read address per cycle
    typedef struct packed {
        logic  we;
        idx_t  waddr;
        data_t wkey;
        data_t wval;
        idx_t  raddr;
    } mem_req_t;

    typedef struct packed {
        data_t key;
        data_t value;
    } entry_t;

    localparam cnt_t DEPTH_CNT = CNT_W'(DEPTH);
    localparam cap_t CAP_RESET = CAP_W'(16);

endpackage

// ===== sv/tvkt_store.sv =====
// key and value memory with one write port and one registered read port
module tvkt_store
    import tvkt_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rd
);

    data_t key_mem [DEPTH];
    data_t val_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            key_mem[req.waddr] <= req.wkey;
            val_mem[req.waddr] <= req.wval;
        end
        rd.key   <= key_mem[req.raddr];
        rd.value <= val_mem[req.raddr];
    end

endmodule

// ===== sv/tvkt_ctrl.sv =====
// sequencer: scans the store one entry a cycle through a key and a value comparator
module tvkt_ctrl
    import tvkt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cap_t     capacity,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_t      in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output out_t     out_data,
    output mem_req_t mem_req,
    input  entry_t   mem_rd
);

    state_t  state_reg, state_next;
    op_t     op_reg, op_next;
    data_t   key_reg, key_next;
    data_t   val_reg, val_next;
    cnt_t    scan_idx_reg, scan_idx_next;
    idx_t    hole_reg, hole_next;
    status_t status_reg, status_next;
    data_t   v1_reg, v1_next;
    data_t   v2_reg, v2_next;
    logic    f1_reg, f1_next;
    logic    f2_reg, f2_next;
    cnt_t    count_reg, count_next;
    logic    out_valid_reg, out_valid_next;
    out_t    out_reg, out_next;

    cnt_t eff_cap;
    logic key_eq;
    logic val_eq;
    logic scan_end;
    logic out_free;
    logic is_search;

    always_comb
    begin
        if (capacity == '0)
            eff_cap = CNT_W'(1);
        else if (CNT_W'(capacity) > DEPTH_CNT)
            eff_cap = DEPTH_CNT;
        else
            eff_cap = CNT_W'(capacity);
    end

    // the key and value compare units
    assign key_eq    = (mem_rd.key == key_reg);
    assign val_eq    = (mem_rd.value == val_reg);
    assign scan_end  = (scan_idx_reg >= count_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_search = (op_reg == OP_SEARCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        scan_idx_reg <= scan_idx_next;
        hole_reg     <= hole_next;
        status_reg   <= status_next;
        v1_reg       <= v1_next;
        v2_reg       <= v2_next;
        f1_reg       <= f1_next;
        f2_reg       <= f2_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        scan_idx_next  = scan_idx_reg;
        hole_next      = hole_reg;
        status_next    = status_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = count_reg[IDX_W-1:0];
        mem_req.wkey  = key_reg;
        mem_req.wval  = val_reg;
        mem_req.raddr = '0;

        // result taken downstream
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = in_data.operation;
                    key_next      = in_data.key;
                    val_next      = in_data.value;
                    scan_idx_next = '0;
                    v1_next       = '0;
                    v2_next       = '0;
                    f1_next       = 1'b0;
                    f2_next       = 1'b0;
                    status_next   = ST_MISS;
                    if (in_data.operation == OP_ADD && count_reg >= eff_cap)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_EMIT;
                    end
                    else if (in_data.operation == OP_NONE)
                        state_next = S_EMIT;
                    else
                        state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // read data arrives in the cycle after its address is given
                mem_req.raddr = scan_idx_reg[IDX_W-1:0] + IDX_W'(1);
                scan_idx_next = scan_idx_reg + CNT_W'(1);
                if (scan_end)
                begin
                    state_next = S_EMIT;
                    case (op_reg)
                        OP_ADD:
                        begin
                            mem_req.we  = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_OK;
                        end
                        OP_SEARCH:
                            status_next = f1_reg ? ST_OK : ST_MISS;
                        default:
                            status_next = ST_MISS;
                    endcase
                end
                else if (key_eq)
                begin
                    case (op_reg)
                        OP_ADD:
                        begin
                            f1_next = 1'b1;
                            if (f1_reg)
                            begin
                                status_next = ST_MISS;
                                state_next  = S_EMIT;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (!f1_reg)
                            begin
                                v1_next = mem_rd.value;
                                f1_next = 1'b1;
                            end
                            else
                            begin
                                v2_next     = mem_rd.value;
                                f2_next     = 1'b1;
                                status_next = ST_OK;
                                state_next  = S_EMIT;
                            end
                        end
                        default:
                        begin
                            if (val_eq)
                            begin
                                hole_next  = scan_idx_reg[IDX_W-1:0];
                                state_next = S_MOVE_RD;
                            end
                        end
                    endcase
                end
            end

            S_MOVE_RD:
            begin
                mem_req.raddr = IDX_W'(count_reg - CNT_W'(1));
                state_next    = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                // last entry fills the hole
                mem_req.we    = 1'b1;
                mem_req.waddr = hole_reg;
                mem_req.wkey  = mem_rd.key;
                mem_req.wval  = mem_rd.value;
                count_next    = count_reg - CNT_W'(1);
                status_next   = ST_OK;
                state_next    = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next.status       = status_reg;
                    out_next.first_value  = is_search ? v1_reg : '0;
                    out_next.first_found  = is_search && f1_reg;
                    out_next.second_value = is_search ? v2_reg : '0;
                    out_next.second_found = is_search && f2_reg;
                    out_next.entry_count  = count_reg;
                    out_next.is_empty     = (count_reg == '0);
                    out_next.is_full      = (count_reg >= eff_cap);
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/two_value_key_table_top.sv =====
// top level of the two value key table: capacity register, sequencer and store
//
//  port group            dir  handshake               payload
//  in_valid/in_stall     in   valid high, stall low  in_data  (operation, key, value)
//  out_valid/out_stall   out  valid high, stall low  out_data (status, values, count, flags)
//  cfg_we/cfg_wdata      in   write enable only       capacity_in_use
//
//  a transaction compares the n stored pairs in turn, n being the stored pair count: the
//  single read port of the store delivers one entry per cycle to the comparators
//  a remove that hits then reads the last pair and writes it into the freed slot
//  a full add or a no operation skips the scan; an add or search scan stops early on a
//  second key hit; the next transaction can be taken in the cycle after the result is loaded
//  reset empties the table (count 0, capacity 16); store contents are not cleared
//  a held result stalls the sequencer only when the next result is ready to load
module two_value_key_table_top
    import tvkt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data,
    input  logic cfg_we,
    input  cap_t cfg_wdata
);

    cap_t     capacity_reg;
    mem_req_t mem_req;
    entry_t   mem_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (cfg_we)
            capacity_reg <= cfg_wdata;
    end

    tvkt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .mem_req   (mem_req),
        .mem_rd    (mem_rd)
    );

    tvkt_store u_store (
        .clk (clk),
        .req (mem_req),
        .rd  (mem_rd)
    );

endmodule

// ===== sv/tvkt_checker.sv =====
// port level checks of the two value key table, bound to the top level
`include "assert_macros.svh"

module tvkt_checker
    import tvkt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    logic in_take;
    logic out_held;
    logic empty_ok;
    logic full_err;
    logic found_ok;

    assign in_take  = in_valid && !in_stall;
    assign out_held = out_valid && out_stall;
    assign empty_ok = (out_data.is_empty == (out_data.entry_count == '0));
    assign full_err = out_valid && (out_data.status == ST_FULL);
    // a second value never shows without a first, an absent first value reads zero
    assign found_ok = (!out_data.second_found || out_data.first_found)
                   && (out_data.first_found || out_data.first_value == '0);

    // one transaction at a time: busy right after taking one
    `TVKT_ASSERT(a_busy_after_accept, in_take |=> in_stall, "took back to back transactions")

    `TVKT_ASSERT(a_empty_flag, out_valid |-> empty_ok, "empty flag disagrees with count")

    `TVKT_ASSERT(a_full_error, full_err |-> out_data.is_full, "full error without full flag")

    `TVKT_ASSERT(a_found_order, out_valid |-> found_ok, "found flags inconsistent")

    `TVKT_ASSERT(a_out_hold, out_held |=> (out_valid && $stable(out_data)), "stalled result changed")

endmodule

bind two_value_key_table_top tvkt_checker u_tvkt_checker (.*);
